// ----- rtl/core/pse_pkg.sv -----
package pse_pkg;

  // fixed field widths of the item and result
  localparam int KIND_W   = 2;
  localparam int POSF_W   = 5;
  localparam int LETTER_W = 5;
  localparam int VALIN_W  = 32;
  localparam int ACC_W    = 48;
  localparam int SEQ_W    = 16;
  localparam int LEN_W    = 6;

  // parameter defaults
  localparam int DEF_MAX_LEN     = 32;
  localparam int DEF_ALPHABET    = 21;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [LEN_W-1:0] SEQ_LEN_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_FIELD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUPLING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESIDUE  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [POSF_W-1:0]          pos_i;
    logic [LETTER_W-1:0]        letter_a;
    logic [POSF_W-1:0]          pos_j;
    logic [LETTER_W-1:0]        letter_b;
    logic signed [VALIN_W-1:0]  value;
    logic [LETTER_W-1:0]        residue;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] neg_energy;
    logic [SEQ_W-1:0]        seq_number;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_status_t;

endpackage

// ----- rtl/core/pse_ram.sv -----
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pse_walk.sv -----
module pse_walk import pse_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int ALPHABET    = DEF_ALPHABET,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   start,
  input  logic [$clog2(MAX_LEN)-1:0]                             start_cnt,
  input  logic [$clog2(MAX_LEN*ALPHABET)-1:0]                    start_col,
  input  logic [VALUE_WIDTH-1:0]                                 start_fld,
  output logic [$clog2(MAX_LEN)-1:0]                             sym_raddr,
  input  logic [LETTER_W-1:0]                                    sym_rdata,
  output logic [$clog2(MAX_LEN*ALPHABET*MAX_LEN*ALPHABET)-1:0]   cpl_raddr,
  input  logic [VALUE_WIDTH-1:0]                                 cpl_rdata,
  output walk_status_t                                           status,
  output logic [ACC_W-1:0]                                       sum
);

  localparam int FIELD_DEPTH = MAX_LEN * ALPHABET;
  localparam int CPL_DEPTH   = FIELD_DEPTH * FIELD_DEPTH;
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int FIELD_AW    = $clog2(FIELD_DEPTH);
  localparam int CPL_AW      = $clog2(CPL_DEPTH);
  localparam int STRIDE      = ALPHABET * FIELD_DEPTH;

  logic                busy;
  logic [POS_W-1:0]    cnt;
  logic [POS_W-1:0]    idx;
  logic [FIELD_AW-1:0] col;
  logic [CPL_AW-1:0]   base;
  logic                s1_vld;
  logic [CPL_AW-1:0]   s1_base;
  logic                s2_vld;
  logic [CPL_AW-1:0]   cpl_addr;
  logic                s3_vld;
  logic [ACC_W-1:0]    acc;
  logic                issue;
  logic                done;

  assign issue = busy && (idx != cnt);
  assign done  = busy && (idx == cnt) && !s1_vld && !s2_vld && !s3_vld;

  assign sym_raddr = idx;
  assign cpl_raddr = cpl_addr;
  assign sum       = acc;

  always_comb begin
    status.busy = busy;
    status.done = done;
  end

  // stage 0: symbol read, stage 1: coupling address, stage 2: coupling read
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= start_cnt;
      col  <= start_col;
      idx  <= '0;
      base <= '0;
      acc  <= ACC_W'($signed(start_fld));
    end else begin
      if (issue) begin
        idx  <= idx + POS_W'(1);
        base <= base + CPL_AW'(STRIDE);
      end
      if (s3_vld) begin
        acc <= acc + ACC_W'($signed(cpl_rdata));
      end
    end
    s1_base  <= base;
    cpl_addr <= s1_base + CPL_AW'(sym_rdata) * CPL_AW'(FIELD_DEPTH) + CPL_AW'(col);
  end

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    done |=> !s1_vld && !s2_vld && !s3_vld)
    else $error("walk finished with reads in flight");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !s2_vld || $past(s1_vld))
    else $error("coupling read without a symbol read");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("walk started while busy");

endmodule

// ----- rtl/core/potts_sequence_energy.sv -----
// Potts sequence energy scorer.
// Item channel (item_valid / item_stall / item): one item is taken when
// item_valid is high and item_stall is low. Kind field or coupling writes
// an entry of the field or coupling table; kind residue adds one residue
// of the current sequence. Items with an out-of-range index are dropped.
// Result channel (result_valid / result_stall / result): one result after
// every seq_len residues, carrying the negated energy and a wrapping
// sequence number.
// cfg_wen / cfg_wdata write seq_len (0 acts as 1, above MAX_LEN as MAX_LEN).
// The user must write it only while the block is idle; nothing enforces it.
// A table write passes through the index, address and write states. A
// residue passes through index, address, fetch, walk and tally; the coupling
// walk reads one coupling entry per earlier position from the single
// coupling memory read port, behind a 3-stage symbol/address/read pipe.
// The result sits in an output register; the block keeps taking items
// while it waits. Only a sequence-ending residue holds while the
// register is still full and stalled.
// Reset (rst, synchronous) clears position, accumulator, sequence number
// and result_valid and sets seq_len to 32. Table contents are
// undefined until loaded.
module potts_sequence_energy import pse_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int ALPHABET    = DEF_ALPHABET,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  in_t              item,
  output logic             result_valid,
  input  logic             result_stall,
  output out_t             result,
  input  logic             cfg_wen,
  input  logic [LEN_W-1:0] cfg_wdata
);

  localparam int FIELD_DEPTH = MAX_LEN * ALPHABET;
  localparam int CPL_DEPTH   = FIELD_DEPTH * FIELD_DEPTH;
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int FIELD_AW    = $clog2(FIELD_DEPTH);
  localparam int CPL_AW      = $clog2(CPL_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INDEX = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_TALLY = 3'd6;

  logic [2:0]             state;
  in_t                    cur;
  logic [LEN_W-1:0]       seq_len;
  logic [CNT_W-1:0]       eff_len;
  logic [CNT_W-1:0]       position;
  logic [ACC_W-1:0]       acc;
  logic [SEQ_W-1:0]       seq_counter;
  logic [FIELD_AW-1:0]    row_idx;
  logic [FIELD_AW-1:0]    col_idx;
  logic [CPL_AW-1:0]      cpl_waddr;
  logic [VALUE_WIDTH-1:0] entry;
  logic                   accept;
  logic                   item_ok;
  logic                   is_res;
  logic                   out_free;
  logic                   emit;

  logic                   fld_we;
  logic [VALUE_WIDTH-1:0] fld_rdata;
  logic                   cpl_we;
  logic [CPL_AW-1:0]      cpl_raddr;
  logic [VALUE_WIDTH-1:0] cpl_rdata;
  logic                   sym_we;
  logic [POS_W-1:0]       sym_raddr;
  logic [LETTER_W-1:0]    sym_rdata;
  logic                   walk_start;
  walk_status_t           walk_st;
  logic [ACC_W-1:0]       walk_sum;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign is_res     = (cur.kind == KIND_RESIDUE);
  assign entry      = VALUE_WIDTH'(cur.value);
  assign emit       = (state == ST_TALLY) && !(position < eff_len) && out_free;

  always_comb begin
    if (seq_len == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(seq_len) > MAX_LEN) begin
      eff_len = CNT_W'(MAX_LEN);
    end else begin
      eff_len = CNT_W'(seq_len);
    end
  end

  always_comb begin
    unique case (item.kind)
      KIND_FIELD:    item_ok = (int'(item.pos_i) < MAX_LEN) &&
                               (int'(item.letter_a) < ALPHABET);
      KIND_COUPLING: item_ok = (int'(item.pos_i) < MAX_LEN) &&
                               (int'(item.letter_a) < ALPHABET) &&
                               (int'(item.pos_j) < MAX_LEN) &&
                               (int'(item.letter_b) < ALPHABET);
      KIND_RESIDUE:  item_ok = (int'(item.residue) < ALPHABET);
      default:       item_ok = 1'b0;
    endcase
  end

  assign fld_we     = (state == ST_WRITE) && (cur.kind == KIND_FIELD);
  assign cpl_we     = (state == ST_WRITE) && (cur.kind == KIND_COUPLING);
  assign walk_start = (state == ST_FETCH);
  assign sym_we     = (state == ST_WALK) && walk_st.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seq_len      <= SEQ_LEN_RESET;
      position     <= '0;
      acc          <= '0;
      seq_counter  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        seq_len <= cfg_wdata;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && item_ok) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: state <= ST_ADDR;
        ST_ADDR:  state <= is_res ? ST_FETCH : ST_WRITE;
        ST_WRITE: state <= ST_IDLE;
        ST_FETCH: state <= ST_WALK;
        ST_WALK: begin
          if (walk_st.done) begin
            acc      <= acc + walk_sum;
            position <= position + CNT_W'(1);
            state    <= ST_TALLY;
          end
        end
        ST_TALLY: begin
          if (position < eff_len) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            seq_counter  <= seq_counter + SEQ_W'(1);
            position     <= '0;
            acc          <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == ST_INDEX) begin
      // residues index the field table with the current position
      row_idx <= FIELD_AW'(is_res ? FIELD_AW'(position[POS_W-1:0]) : FIELD_AW'(cur.pos_i))
                 * FIELD_AW'(ALPHABET)
                 + FIELD_AW'(is_res ? cur.residue : cur.letter_a);
      col_idx <= FIELD_AW'(cur.pos_j) * FIELD_AW'(ALPHABET) + FIELD_AW'(cur.letter_b);
    end
    if (state == ST_ADDR) begin
      cpl_waddr <= CPL_AW'(row_idx) * CPL_AW'(FIELD_DEPTH) + CPL_AW'(col_idx);
    end
    if (emit) begin
      result.neg_energy <= -acc;
      result.seq_number <= seq_counter;
    end
  end

  pse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (FIELD_DEPTH)
  ) u_field_ram (
    .clk   (clk),
    .we    (fld_we),
    .waddr (row_idx),
    .wdata (entry),
    .raddr (row_idx),
    .rdata (fld_rdata)
  );

  pse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CPL_DEPTH)
  ) u_coupling_ram (
    .clk   (clk),
    .we    (cpl_we),
    .waddr (cpl_waddr),
    .wdata (entry),
    .raddr (cpl_raddr),
    .rdata (cpl_rdata)
  );

  pse_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_LEN)
  ) u_symbol_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (position[POS_W-1:0]),
    .wdata (cur.residue),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  pse_walk #(
    .MAX_LEN     (MAX_LEN),
    .ALPHABET    (ALPHABET),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (walk_start),
    .start_cnt (position[POS_W-1:0]),
    .start_col (row_idx),
    .start_fld (fld_rdata),
    .sym_raddr (sym_raddr),
    .sym_rdata (sym_rdata),
    .cpl_raddr (cpl_raddr),
    .cpl_rdata (cpl_rdata),
    .status    (walk_st),
    .sum       (walk_sum)
  );

  a_done_in_walk: assert property (@(posedge clk) disable iff (rst)
    walk_st.busy || walk_st.done |-> state == ST_WALK)
    else $error("walk active outside walk state");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> int'(position) < MAX_LEN)
    else $error("position out of range while idle");

  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> acc == '0 && position == '0)
    else $error("sequence state not cleared after result");

  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> seq_counter == result.seq_number + SEQ_W'(1))
    else $error("sequence number out of step");

endmodule
